FILE: src/stcp_pkg.sv
`default_nettype none

package stcp_pkg;

  localparam int unsigned LEN_BITS = 32;
  localparam int unsigned NAME_BITS = 8;
  localparam logic [NAME_BITS-1:0] NAME_MAX = NAME_BITS'(254);

  // ascii codes
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] OpM     = 8'h4d;
  localparam logic [7:0] OpI     = 8'h49;
  localparam logic [7:0] OpD     = 8'h44;
  localparam logic [7:0] OpN     = 8'h4e;
  localparam logic [7:0] OpS     = 8'h53;
  localparam logic [7:0] OpH     = 8'h48;
  localparam logic [7:0] OpP     = 8'h50;
  localparam logic [7:0] OpEq    = 8'h3d;
  localparam logic [7:0] OpX     = 8'h58;
  localparam logic [7:0] OpB     = 8'h42;

  typedef enum logic [2:0] {
    PhName,
    PhPos,
    PhStrandFirst,
    PhStrandRest,
    PhCigar,
    PhSkip
  } phase_e;

  typedef struct packed {
    logic [7:0] tag_byte;
    logic       string_end;
  } in_t;

  typedef struct packed {
    logic [LEN_BITS-1:0]  start_clip;
    logic [LEN_BITS-1:0]  end_clip;
    logic                 negative_strand;
    logic [NAME_BITS-1:0] name_length;
    logic                 from_final_byte;
  } out_t;

  typedef struct packed {
    phase_e               phase;
    logic [LEN_BITS-1:0]  digit_accum;
    logic                 seen_digit;
    logic                 in_leading;
    logic [LEN_BITS-1:0]  lead_sum;
    logic [LEN_BITS-1:0]  trail_sum;
    logic                 strand_flag;
    logic [NAME_BITS-1:0] name_count;
  } state_t;

  localparam state_t StateReset = '{
    phase:       PhName,
    digit_accum: '0,
    seen_digit:  1'b0,
    in_leading:  1'b1,
    lead_sum:    '0,
    trail_sum:   '0,
    strand_flag: 1'b0,
    name_count:  '0
  };

endpackage

`default_nettype wire

FILE: src/stcp_step.sv
`default_nettype none

module stcp_step (
  input  stcp_pkg::state_t st_i,
  input  stcp_pkg::in_t    item_i,
  output stcp_pkg::state_t st_o,
  output logic             close_o,
  output stcp_pkg::out_t   res_o
);
  import stcp_pkg::*;

  localparam int unsigned WideBits = LEN_BITS + 4;

  function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                  input logic [LEN_BITS-1:0] b);
    logic [LEN_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
  endfunction

  logic [7:0]          c;
  logic                last;
  logic                is_digit;
  logic [3:0]          digit;
  logic [WideBits-1:0] accum_x10;
  logic [WideBits-1:0] accum_new;
  logic                check_semi;
  state_t              st_upd;

  assign c        = item_i.tag_byte;
  assign last     = item_i.string_end;
  assign is_digit = (c >= ChZero) && (c <= ChNine);
  assign digit    = 4'(c - ChZero);

  // x10 as two shifts
  assign accum_x10 = {1'b0, st_i.digit_accum, 3'b000} + {3'b000, st_i.digit_accum, 1'b0};
  assign accum_new = accum_x10 + WideBits'(digit);

  always_comb begin
    st_upd     = st_i;
    check_semi = 1'b0;
    case (st_i.phase)
      PhName: begin
        if (c == ChComma) begin
          st_upd.phase = PhPos;
        end else if (st_i.name_count < NAME_MAX) begin
          st_upd.name_count = st_i.name_count + NAME_BITS'(1);
        end
      end
      PhPos: begin
        if (c == ChComma) st_upd.phase = PhStrandFirst;
      end
      PhStrandFirst: begin
        st_upd.strand_flag = (c == ChMinus);
        st_upd.phase       = (c == ChComma) ? PhCigar : PhStrandRest;
      end
      PhStrandRest: begin
        if (c == ChComma) st_upd.phase = PhCigar;
      end
      PhCigar: begin
        if (is_digit) begin
          st_upd.digit_accum = (accum_new[WideBits-1:LEN_BITS] != '0) ?
                               {LEN_BITS{1'b1}} : accum_new[LEN_BITS-1:0];
          st_upd.seen_digit  = 1'b1;
        end else if (!st_i.seen_digit) begin
          // op with no length ends the cigar
          st_upd.phase = PhSkip;
          check_semi   = 1'b1;
        end else begin
          if (c inside {OpS, OpH}) begin
            if (st_i.in_leading) begin
              st_upd.lead_sum = sat_add(st_i.lead_sum, st_i.digit_accum);
            end else begin
              st_upd.trail_sum = sat_add(st_i.trail_sum, st_i.digit_accum);
            end
          end else if (c inside {OpM, OpI, OpD, OpN, OpP, OpEq, OpX, OpB}) begin
            st_upd.in_leading = 1'b0;
          end else begin
            st_upd.phase = PhSkip;
          end
          st_upd.digit_accum = '0;
          st_upd.seen_digit  = 1'b0;
        end
      end
      default: begin
        st_upd.phase = PhSkip;
        check_semi   = 1'b1;
      end
    endcase
  end

  assign close_o = (check_semi && (c == ChSemi)) ||
                   (last && ((st_upd.phase == PhCigar) || (st_upd.phase == PhSkip)));

  assign res_o.start_clip      = st_upd.lead_sum;
  assign res_o.end_clip        = st_upd.trail_sum;
  assign res_o.negative_strand = st_upd.strand_flag;
  assign res_o.name_length     = st_upd.name_count;
  assign res_o.from_final_byte = last;

  assign st_o = (close_o || last) ? StateReset : st_upd;

endmodule

`default_nettype wire

FILE: src/sa_tag_clip_parser.sv
// throughput: one character per cycle while no result is stalled downstream;
// the parse state is one register updated per byte
// the input register drains into the result register whenever the result slot is free
// or being taken, so input ready only drops while a result is stalled downstream
// reset (rst_ni low, asynchronous): both registers empty, parser back at a record name
`default_nettype none

module sa_tag_clip_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  stcp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output stcp_pkg::out_t out_data_o
);
  import stcp_pkg::*;

  // input register
  logic   in_vld_q;
  in_t    in_q;

  // parse state
  state_t st_q;
  state_t st_d;

  // result register
  logic   out_vld_q;
  out_t   out_q;

  logic   close;
  out_t   res;
  logic   advance;

  // the byte in the input register is parsed when its result (if any) has a place
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  stcp_step u_step (
    .st_i    (st_q),
    .item_i  (in_q),
    .st_o    (st_d),
    .close_o (close),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= StateReset;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        st_q <= st_d;
      end
      // a record closed now replaces a result being taken in the same cycle
      if (advance && close) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance && close) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // the end of the string always leaves the parser at a fresh record name
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.string_end |=> st_q.phase == PhName && !st_q.seen_digit)
    else $error("parser state not cleared after string end");

  // pending digits only exist inside the cigar
  a_digits_in_cigar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.seen_digit |-> st_q.phase == PhCigar)
    else $error("digit flag set outside cigar");

  // name length never passes its cap
  a_name_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.name_count <= NAME_MAX)
    else $error("name count above cap");

  // a stalled result must not be overwritten by a new record
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |-> !advance)
    else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_sa_tag_clip_parser.sv
module tb_sa_tag_clip_parser;
  import stcp_pkg::*;

  // characters used only by the stimulus
  localparam logic [7:0] ChPlus = 8'h2b;

  // cycles without any transaction before the run is declared hung
  localparam int unsigned HangLimit = 4000;
  // after its closing byte is taken a result passes the input and result registers, these cycles cover the tail
  localparam int unsigned DrainCycles = 8;
  // printed mismatch lines are capped, every mismatch is still counted
  localparam int unsigned ReportCap = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // input channel
  logic in_valid = 1'b0;
  logic in_ready_o;
  in_t  in_char = '0;

  // output channel
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_t out_rec;

  // idle rates in percent, changed between phases
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  // characters waiting to be driven and records waiting to come out
  in_t  pending_chars[$];
  out_t clips_due[$];
  logic [7:0] tag_buf[$];

  // run statistics
  int unsigned mismatches = 0;
  int unsigned chars_sent = 0;
  int unsigned tags_built = 0;
  int unsigned records_checked = 0;
  int unsigned saturated_seen = 0;
  int unsigned truncated_seen = 0;
  int unsigned final_closes = 0;
  int unsigned hang_count = 0;

  // parser state mirrored by the predictor
  phase_e              ph = PhName;
  logic [LEN_BITS-1:0] len_acc = '0;
  logic                have_digit = 1'b0;
  logic                leading = 1'b1;
  logic [LEN_BITS-1:0] lead_sum = '0;
  logic [LEN_BITS-1:0] trail_sum = '0;
  logic                minus = 1'b0;
  logic [7:0]          name_len = '0;

  sa_tag_clip_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_char),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_rec)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // clip predictor
  // ---------------------------------------------------------------------------

  function automatic logic [LEN_BITS-1:0] sat_sum(logic [LEN_BITS-1:0] a,
                                                  logic [LEN_BITS-1:0] b);
    logic [LEN_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
  endfunction

  task automatic reset_parse();
    ph = PhName;
    len_acc = '0;
    have_digit = 1'b0;
    leading = 1'b1;
    lead_sum = '0;
    trail_sum = '0;
    minus = 1'b0;
    name_len = '0;
  endtask

  // advance the mirrored parser by one accepted character, queue a record if it closes
  task automatic predict_clips(input in_t ch);
    logic [7:0]          c;
    logic                last;
    logic                semi_closes;
    logic                closes;
    logic [LEN_BITS+3:0] grown;
    out_t                rec;
    c = ch.tag_byte;
    last = ch.string_end;
    semi_closes = 1'b0;
    closes = 1'b0;
    case (ph)
      PhName: begin
        if (c == ChComma) ph = PhPos;
        else if (name_len < NAME_MAX) name_len = name_len + 8'd1;
      end
      PhPos: begin
        if (c == ChComma) ph = PhStrandFirst;
      end
      PhStrandFirst: begin
        // only the first strand byte decides, a comma here is already the third one
        minus = (c == ChMinus);
        ph = (c == ChComma) ? PhCigar : PhStrandRest;
      end
      PhStrandRest: begin
        if (c == ChComma) ph = PhCigar;
      end
      PhCigar: begin
        if (c >= ChZero && c <= ChNine) begin
          grown = {4'b0, len_acc} * (LEN_BITS + 4)'(10) + (LEN_BITS + 4)'(c - ChZero);
          len_acc = (grown > {4'b0, {LEN_BITS{1'b1}}}) ? {LEN_BITS{1'b1}}
                                                        : grown[LEN_BITS-1:0];
          have_digit = 1'b1;
        end else if (!have_digit) begin
          // op with no length ends the cigar, the byte itself counts as skipped
          ph = PhSkip;
          semi_closes = 1'b1;
        end else begin
          // any byte after digits is the op letter, even a separator
          case (c)
            OpS, OpH: begin
              if (leading) lead_sum = sat_sum(lead_sum, len_acc);
              else trail_sum = sat_sum(trail_sum, len_acc);
            end
            OpM, OpI, OpD, OpN, OpP, OpEq, OpX, OpB: leading = 1'b0;
            default: ph = PhSkip;
          endcase
          len_acc = '0;
          have_digit = 1'b0;
        end
      end
      default: begin
        ph = PhSkip;
        semi_closes = 1'b1;
      end
    endcase
    if (semi_closes && c == ChSemi) closes = 1'b1;
    if (last && (ph == PhCigar || ph == PhSkip)) closes = 1'b1;
    if (closes) begin
      rec.start_clip = lead_sum;
      rec.end_clip = trail_sum;
      rec.negative_strand = minus;
      rec.name_length = name_len;
      rec.from_final_byte = last;
      clips_due.push_back(rec);
    end
    // string end always drops a record that never reached its cigar
    if (closes || last) reset_parse();
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= ReportCap) $display("mismatch at record %0d: %s", records_checked, msg);
  endtask

  task automatic compare_field(string field, logic [LEN_BITS-1:0] got,
                               logic [LEN_BITS-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
  endtask

  task automatic check_record(input out_t got);
    out_t want;
    if (clips_due.size() == 0) begin
      report_mismatch($sformatf("result with no record pending (start_clip %0d)",
                                got.start_clip));
      return;
    end
    want = clips_due.pop_front();
    compare_field("start_clip", got.start_clip, want.start_clip);
    compare_field("end_clip", got.end_clip, want.end_clip);
    compare_field("negative_strand", LEN_BITS'(got.negative_strand),
                  LEN_BITS'(want.negative_strand));
    compare_field("name_length", LEN_BITS'(got.name_length), LEN_BITS'(want.name_length));
    compare_field("from_final_byte", LEN_BITS'(got.from_final_byte),
                  LEN_BITS'(want.from_final_byte));
    records_checked++;
    if (&want.start_clip || &want.end_clip) saturated_seen++;
    if (want.name_length == NAME_MAX) truncated_seen++;
    if (want.from_final_byte) final_closes++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: one character per transaction, valid held until accepted
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        predict_clips(in_char);
        chars_sent++;
      end
      // a new character may go out only once the current one is taken
      if (!in_valid || in_ready_o) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_char <= pending_chars.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transaction and stalls at random
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) check_record(out_rec);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: any transaction on either side counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        hang_count <= 0;
      end else if (hang_count >= HangLimit) begin
        $display("no transaction for %0d cycles, %0d records still pending",
                 HangLimit, clips_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        hang_count <= hang_count + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) tag_buf.push_back(s[i]);
  endtask

  // close the tag string under construction: its last character carries string_end
  task automatic flush_tag();
    if (tag_buf.size() == 0) tag_buf.push_back(ChSemi);
    foreach (tag_buf[i]) begin
      pending_chars.push_back(in_t'{tag_byte: tag_buf[i],
                                    string_end: (i == tag_buf.size() - 1)});
    end
    tag_buf.delete();
    tags_built++;
  endtask

  // mostly short lengths, sometimes zero, leading zeros or large values near or past the saturation point
  function automatic string pick_length(bit big);
    int unsigned k;
    k = $urandom_range(99);
    if (big || k < 4) begin
      case ($urandom_range(3))
        0:       return "4294967295";
        1:       return "4294967296";
        2:       return "3000000000";
        default: return "99999999999";
      endcase
    end
    if (k < 8) return "0";
    if (k < 11) return $sformatf("00%0d", $urandom_range(1, 99));
    return $sformatf("%0d", $urandom_range(1, 999));
  endfunction

  function automatic logic [7:0] pick_clip_op();
    return $urandom_range(1) ? OpS : OpH;
  endfunction

  function automatic logic [7:0] pick_other_op();
    case ($urandom_range(7))
      0:       return OpM;
      1:       return OpI;
      2:       return OpD;
      3:       return OpN;
      4:       return OpP;
      5:       return OpEq;
      6:       return OpX;
      default: return OpB;
    endcase
  endfunction

  // name bytes never hold a comma but may hold separators and non-ascii bytes
  function automatic logic [7:0] pick_name_char();
    case ($urandom_range(19))
      0:       return ChSemi;
      1:       return 8'($urandom_range(128, 255));
      2:       return ChMinus;
      3:       return 8'($urandom_range(0, 31));
      4:       return 8'($urandom_range(ChZero, ChNine));
      default: return 8'($urandom_range(8'h61, 8'h7a));
    endcase
  endfunction

  task automatic add_op(bit big, logic [7:0] op);
    add_text(pick_length(big));
    tag_buf.push_back(op);
  endtask

  // one record; must_end tells the caller the string has to stop here
  task automatic add_record(output bit must_end);
    int unsigned kind;
    int unsigned n;
    bit big;
    kind = $urandom_range(99);
    big = ($urandom_range(99) < 4);
    must_end = 1'b0;
    // noise: arbitrary bytes, string end brings the parser back
    if (kind >= 93) begin
      repeat ($urandom_range(1, 30)) tag_buf.push_back(8'($urandom_range(0, 255)));
      must_end = 1'b1;
      return;
    end
    n = ($urandom_range(99) < 5) ? $urandom_range(240, 300) : $urandom_range(0, 10);
    repeat (n) tag_buf.push_back(pick_name_char());
    // string cut before the third comma
    if (kind >= 85) begin
      repeat ($urandom_range(0, 2)) begin
        tag_buf.push_back(ChComma);
        add_text(pick_length(1'b0));
      end
      must_end = 1'b1;
      return;
    end
    tag_buf.push_back(ChComma);
    add_text(pick_length(1'b0));
    if ($urandom_range(19) == 0) tag_buf.push_back(ChSemi);
    tag_buf.push_back(ChComma);
    case ($urandom_range(9))
      0: ;
      1: begin
        tag_buf.push_back(ChMinus);
        tag_buf.push_back(8'($urandom_range(8'h61, 8'h7a)));
      end
      2, 3, 4, 5: tag_buf.push_back(ChMinus);
      default: tag_buf.push_back(ChPlus);
    endcase
    tag_buf.push_back(ChComma);
    // leading clips, body, then a mix of trailing clips and further ops
    repeat ($urandom_range(0, 2)) add_op(big, pick_clip_op());
    repeat ($urandom_range(1, 4)) add_op(1'b0, pick_other_op());
    repeat ($urandom_range(0, 3)) begin
      add_op(big, $urandom_range(2) != 0 ? pick_clip_op() : pick_other_op());
    end
    // broken cigar tails
    if (kind >= 75) begin
      case ($urandom_range(2))
        0: tag_buf.push_back($urandom_range(1) ? pick_other_op() : pick_clip_op());
        1: begin
          add_text(pick_length(1'b0));
          case ($urandom_range(2))
            0:       tag_buf.push_back(ChSemi);
            1:       tag_buf.push_back(ChComma);
            default: tag_buf.push_back(8'($urandom_range(8'h61, 8'h7a)));
          endcase
        end
        default: add_text(pick_length(1'b0));
      endcase
      repeat ($urandom_range(0, 1)) add_op(1'b0, pick_clip_op());
    end
  endtask

  // tag strings of one to four records until both minimums are met
  task automatic build_tags(int unsigned min_chars, int unsigned min_records);
    int unsigned chars;
    int unsigned records;
    int unsigned nrec;
    bit must_end;
    chars = 0;
    records = 0;
    while (chars < min_chars || records < min_records) begin
      nrec = $urandom_range(1, 4);
      for (int i = 0; i < nrec; i++) begin
        add_record(must_end);
        records++;
        if (must_end) break;
        if (i < nrec - 1 || $urandom_range(1) != 0) tag_buf.push_back(ChSemi);
      end
      chars += tag_buf.size();
      flush_tag();
    end
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender rarely idles, receiver often stalls
    send_gap_pct = 6;
    recv_stall_pct = 46;
    // directed string: empty fields with the strand byte being the third comma and an op
    // without length, a semicolon inside the position and a bare semicolon as cigar,
    // a semicolon taken as op letter, then a string cut after one comma
    add_text(",,,M;x,;,-,;c,,,2S5;;q,1");
    flush_tag();
    build_tags(360, 8);
    wait_drained();

    // sender often idles, receiver rarely stalls
    @(negedge clk_i);
    send_gap_pct = 46;
    recv_stall_pct = 6;
    build_tags(360, 8);
    wait_drained();

    // back to back in both directions
    @(negedge clk_i);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    build_tags(360, 8);
    wait_drained();

    while (in_valid || clips_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (clips_due.size() != 0) report_mismatch($sformatf("%0d records never came out",
                                                         clips_due.size()));

    $display("sent %0d characters in %0d tag strings, %0d records checked",
             chars_sent, tags_built, records_checked);
    $display("%0d with a saturated clip sum, %0d with a truncated name, %0d closed at string end",
             saturated_seen, truncated_seen, final_closes);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sa_tag_clip_parser.f
src/stcp_pkg.sv
src/stcp_step.sv
src/sa_tag_clip_parser.sv
tb/tb_sa_tag_clip_parser.sv
